### rtl/swcrc_pkg.sv
package swcrc_pkg;

  localparam int MAX_PACKET_BYTES = 1024;
  localparam int HEADER_BYTES     = 8;
  localparam int SEQ_START        = 4;

  localparam int POS_W   = $clog2(MAX_PACKET_BYTES + 1);
  localparam int PPC_W   = $clog2(MAX_PACKET_BYTES);
  localparam int SEQ_W   = 14;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [7:0]  ASCII_ZERO = 8'd48;
  localparam logic [7:0]  ASCII_NINE = 8'd57;
  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [1:0] {
    VD_ACK_NEW   = 2'd0,
    VD_ACK_DUP   = 2'd1,
    VD_RESEND    = 2'd2,
    VD_SEQ_AHEAD = 2'd3
  } verdict_e;

  // What one input word leaves for the output side: up to two results.
  typedef struct packed {
    logic             has_pay;
    logic [7:0]       pay_byte;
    logic             has_vd;
    verdict_e         vd;
    logic [SEQ_W-1:0] seq;
    logic [31:0]      commit_pre;
    logic             done_pre;
    logic [31:0]      commit_post;
    logic             done_post;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Reflected CRC-32 update over one byte.
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

### rtl/stop_wait_crc32_packet_receiver.sv
// Channel   Direction  Words
// s_axis    in         packet bytes, tlast on the last byte of a packet
// m_axis    out        payload bytes (tuser 0) and packet verdicts (tuser 1)
// apb       in/out     register 0: file_size
//
// One byte is taken every cycle while the four-entry queue between the
// parsing front and the output stage has room. A last byte that also carries
// payload yields two words, sent by the output stage one after the other;
// the queue absorbs this, so the sustained rate is one byte per cycle while
// m_axis is not stalled. Reset is asynchronous and needs no clearing pass.
module stop_wait_crc32_packet_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] payload_byte, [9:8] verdict, [23:10] packet_seq,
  // [55:24] bytes_committed, [56] transfer_done, [63:57] zero
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tuser,   // [0] item_kind
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_FILE_SIZE = 1'b0;

  logic [31:0]         file_size_q, file_size_d;
  logic                push;
  logic                pop;
  swcrc_pkg::q_entry_t push_entry;
  swcrc_pkg::q_entry_t head_entry;
  swcrc_pkg::q_stat_t  q_stat;
  logic                reg_wr;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite;

  always_comb begin
    file_size_d = file_size_q;
    if (reg_wr && paddr[2] == REG_FILE_SIZE) begin
      file_size_d = pwdata;
    end
    prdata = (paddr[2] == REG_FILE_SIZE) ? file_size_q : 32'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_size_q <= '0;
    end else begin
      file_size_q <= file_size_d;
    end
  end

  swcrc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .rx_byte_i   (s_axis_tdata),
    .eop_i       (s_axis_tlast),
    .file_size_i (file_size_q),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  swcrc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .stat_o  (q_stat)
  );

  swcrc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (head_entry),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_kind_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

`ifndef SYNTHESIS
  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("queue written while full");

  a_no_pop_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("queue read while empty");

  a_verdict_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == swcrc_pkg::KIND_VERDICT) |-> m_axis_tlast)
    else $error("verdict word without tlast");

  a_payload_no_verdict : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == swcrc_pkg::KIND_PAYLOAD) |->
      m_axis_tdata[9:8] == 2'd0)
    else $error("payload word carries a verdict code");
`endif

endmodule

### rtl/swcrc_front.sv
module swcrc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          rx_byte_i,
  input  logic                eop_i,
  input  logic [31:0]         file_size_i,
  input  swcrc_pkg::q_stat_t  q_stat_i,
  output logic                push_o,
  output swcrc_pkg::q_entry_t entry_o
);

  localparam logic [swcrc_pkg::POS_W-1:0] PosMax =
    swcrc_pkg::POS_W'(swcrc_pkg::MAX_PACKET_BYTES);
  localparam logic [swcrc_pkg::POS_W-1:0] PosSeq =
    swcrc_pkg::POS_W'(swcrc_pkg::SEQ_START);
  localparam logic [swcrc_pkg::POS_W-1:0] PosHdr =
    swcrc_pkg::POS_W'(swcrc_pkg::HEADER_BYTES);
  localparam logic [swcrc_pkg::POS_W-1:0] PosShort =
    swcrc_pkg::POS_W'(swcrc_pkg::HEADER_BYTES - 1);

  logic [swcrc_pkg::POS_W-1:0] pos_q, pos_d;
  logic [31:0]                 crc_q, crc_d, crc_n;
  logic [31:0]                 rx_crc_q, rx_crc_d, rx_crc_n;
  logic [swcrc_pkg::SEQ_W-1:0] seq_q, seq_d, seq_n;
  logic                        seq_ok_q, seq_ok_d, seq_ok_n;
  logic [swcrc_pkg::SEQ_W-1:0] exp_seq_q, exp_seq_d;
  logic [31:0]                 commit_q, commit_d;
  logic [swcrc_pkg::PPC_W-1:0] ppc_q, ppc_d, ppc_n;
  logic                        done_q, done_d;

  logic        accept;
  logic        in_range;
  logic        pay_emit;
  logic [31:0] room;
  logic [31:0] commit_sum;
  logic        crc_bad;
  logic        short_pkt;
  swcrc_pkg::verdict_e vd;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;
  assign in_range   = pos_q < PosMax;
  assign room       = file_size_i - commit_q;

  always_comb begin
    rx_crc_n = rx_crc_q;
    seq_n    = seq_q;
    seq_ok_n = seq_ok_q;
    crc_n    = crc_q;
    pay_emit = 1'b0;
    if (in_range) begin
      if (pos_q < PosSeq) begin
        rx_crc_n = {rx_crc_q[23:0], rx_byte_i};
      end else if (pos_q < PosHdr) begin
        if (seq_ok_q && rx_byte_i >= swcrc_pkg::ASCII_ZERO &&
            rx_byte_i <= swcrc_pkg::ASCII_NINE) begin
          seq_n = seq_q * swcrc_pkg::SEQ_W'(10) +
                  swcrc_pkg::SEQ_W'(rx_byte_i - swcrc_pkg::ASCII_ZERO);
        end else begin
          seq_ok_n = 1'b0;
        end
      end else begin
        crc_n    = swcrc_pkg::crc_byte(crc_q, rx_byte_i);
        pay_emit = (commit_q < file_size_i) && (32'(ppc_q) < room);
      end
    end
    ppc_n = ppc_q + swcrc_pkg::PPC_W'(pay_emit);
  end

  // Verdict on the last byte of a packet.
  always_comb begin
    short_pkt  = pos_q < PosShort;
    crc_bad    = (~crc_n) != rx_crc_n;
    commit_sum = commit_q + 32'(ppc_n);
    if (short_pkt || crc_bad) begin
      vd = swcrc_pkg::VD_RESEND;
    end else if (exp_seq_q < seq_n) begin
      vd = swcrc_pkg::VD_SEQ_AHEAD;
    end else if (exp_seq_q > seq_n) begin
      vd = swcrc_pkg::VD_ACK_DUP;
    end else begin
      vd = swcrc_pkg::VD_ACK_NEW;
    end
  end

  always_comb begin
    pos_d     = pos_q;
    crc_d     = crc_q;
    rx_crc_d  = rx_crc_q;
    seq_d     = seq_q;
    seq_ok_d  = seq_ok_q;
    exp_seq_d = exp_seq_q;
    commit_d  = commit_q;
    ppc_d     = ppc_q;
    done_d    = done_q;
    if (accept) begin
      if (eop_i) begin
        pos_d    = '0;
        crc_d    = '1;
        rx_crc_d = '0;
        seq_d    = '0;
        seq_ok_d = 1'b1;
        ppc_d    = '0;
        if (vd == swcrc_pkg::VD_ACK_NEW) begin
          commit_d  = commit_sum;
          exp_seq_d = exp_seq_q + swcrc_pkg::SEQ_W'(1);
          if (commit_sum >= file_size_i) begin
            done_d = 1'b1;
          end
        end
      end else begin
        pos_d    = in_range ? pos_q + swcrc_pkg::POS_W'(1) : pos_q;
        crc_d    = crc_n;
        rx_crc_d = rx_crc_n;
        seq_d    = seq_n;
        seq_ok_d = seq_ok_n;
        ppc_d    = ppc_n;
      end
    end
  end

  always_comb begin
    push_o               = accept && (pay_emit || eop_i);
    entry_o.has_pay      = pay_emit;
    entry_o.pay_byte     = rx_byte_i;
    entry_o.has_vd       = eop_i;
    entry_o.vd           = vd;
    entry_o.seq          = seq_n;
    entry_o.commit_pre   = commit_q;
    entry_o.done_pre     = done_q;
    entry_o.commit_post  = (vd == swcrc_pkg::VD_ACK_NEW) ? commit_sum : commit_q;
    entry_o.done_post    = done_q ||
                           ((vd == swcrc_pkg::VD_ACK_NEW) && (commit_sum >= file_size_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      crc_q     <= '1;
      rx_crc_q  <= '0;
      seq_q     <= '0;
      seq_ok_q  <= 1'b1;
      exp_seq_q <= '0;
      commit_q  <= '0;
      ppc_q     <= '0;
      done_q    <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      crc_q     <= crc_d;
      rx_crc_q  <= rx_crc_d;
      seq_q     <= seq_d;
      seq_ok_q  <= seq_ok_d;
      exp_seq_q <= exp_seq_d;
      commit_q  <= commit_d;
      ppc_q     <= ppc_d;
      done_q    <= done_d;
    end
  end

endmodule

### rtl/swcrc_fifo.sv
module swcrc_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  swcrc_pkg::q_entry_t entry_i,
  input  logic                pop_i,
  output swcrc_pkg::q_entry_t entry_o,
  output swcrc_pkg::q_stat_t  stat_o
);

  swcrc_pkg::q_entry_t mem_q [swcrc_pkg::Q_DEPTH];

  logic [swcrc_pkg::Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [swcrc_pkg::Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [swcrc_pkg::Q_CNT_W-1:0] cnt_q, cnt_d;
  logic                          do_push;
  logic                          do_pop;

  assign stat_o.full  = cnt_q == swcrc_pkg::Q_CNT_W'(swcrc_pkg::Q_DEPTH);
  assign stat_o.empty = cnt_q == '0;
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign entry_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + swcrc_pkg::Q_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + swcrc_pkg::Q_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + swcrc_pkg::Q_CNT_W'(do_push) - swcrc_pkg::Q_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

### rtl/swcrc_back.sv
module swcrc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  swcrc_pkg::q_entry_t entry_i,
  input  swcrc_pkg::q_stat_t  q_stat_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [63:0]         out_data_o,
  output logic                out_kind_o,
  output logic                out_last_o
);

  logic        valid_q, valid_d;
  logic        half_q, half_d;
  logic [63:0] data_q, data_d;
  logic        kind_q, kind_d;
  logic        last_q, last_d;
  logic        load;
  logic        emit_vd;

  assign load    = !valid_q || out_ready_i;
  // The verdict goes out once the payload word of the same input has left.
  assign emit_vd = half_q || !entry_i.has_pay;

  always_comb begin
    valid_d = valid_q;
    half_d  = half_q;
    data_d  = data_q;
    kind_d  = kind_q;
    last_d  = last_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = !q_stat_i.empty;
      if (!q_stat_i.empty) begin
        if (emit_vd) begin
          kind_d = swcrc_pkg::KIND_VERDICT;
          last_d = 1'b1;
          data_d = {7'd0, entry_i.done_post, entry_i.commit_post, entry_i.seq,
                    entry_i.vd, 8'd0};
          half_d = 1'b0;
          pop_o  = 1'b1;
        end else begin
          kind_d = swcrc_pkg::KIND_PAYLOAD;
          last_d = !entry_i.has_vd;
          data_d = {7'd0, entry_i.done_pre, entry_i.commit_pre, entry_i.seq,
                    2'd0, entry_i.pay_byte};
          half_d = entry_i.has_vd;
          pop_o  = !entry_i.has_vd;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      half_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      half_q  <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    kind_q <= kind_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_kind_o  = kind_q;
  assign out_last_o  = last_q;

endmodule

### sim/packet_verdict_checker.sv
module packet_verdict_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        s_tlast_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [63:0] m_tdata_i,
  input  logic        m_tuser_i,
  input  logic        m_tlast_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic [31:0] prdata_i,
  input  logic        pready_i,
  output int          fail_count_o,
  output int          words_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] FILE_SIZE_ADDR = 3'd0;

  typedef struct packed {
    logic                        kind;
    logic [7:0]                  data;
    swcrc_pkg::verdict_e         vd;
    logic [swcrc_pkg::SEQ_W-1:0] seq;
    logic [31:0]                 committed;
    logic                        done;
    logic [6:0]                  pad;
    logic                        last;
  } out_word_t;

  // Payload bytes and packet verdicts the receiver still owes, oldest first.
  out_word_t words_due[$];
  int        words_seen;

  logic [31:0]                 size_limit;
  logic [31:0]                 crc_run;
  logic [31:0]                 crc_field;
  int                          hdr_pos;
  logic [swcrc_pkg::SEQ_W-1:0] seq_parsed;
  logic                        seq_digits_ok;
  logic [swcrc_pkg::SEQ_W-1:0] seq_wanted;
  logic [31:0]                 bytes_accepted;
  logic [31:0]                 pkt_emitted;
  logic                        xfer_done;

  function automatic logic [31:0] crc32_next(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c;
    // Bit-serial form: each data bit joins the register's low bit in turn.
    for (int i = 0; i < 8; i++) begin
      r = (r >> 1) ^ ((r[0] ^ b[i]) ? swcrc_pkg::CRC_POLY : 32'd0);
    end
    return r;
  endfunction

  function automatic string show(input out_word_t w);
    return {$sformatf("kind=%0d byte=%02h verdict=%0d seq=%0d",
                      w.kind, w.data, w.vd, w.seq),
            $sformatf(" committed=%0d done=%0d pad=%0h last=%0d",
                      w.committed, w.done, w.pad, w.last)};
  endfunction

  task automatic note_failure(input string msg);
    fail_count_o++;
    if (fail_count_o <= 10) $display("%s", msg);
  endtask

  task automatic start_packet();
    crc_run       = '1;
    crc_field     = '0;
    hdr_pos       = 0;
    seq_parsed    = '0;
    seq_digits_ok = 1'b1;
    pkt_emitted   = '0;
  endtask

  task automatic queue_word(input logic kind, input logic [7:0] data,
                            input swcrc_pkg::verdict_e vd, input logic last);
    out_word_t w;
    w.kind      = kind;
    w.data      = data;
    w.vd        = vd;
    w.seq       = seq_parsed;
    w.committed = bytes_accepted;
    w.done      = xfer_done;
    w.pad       = '0;
    w.last      = last;
    words_due.push_back(w);
  endtask

  task automatic take_link_byte(input logic [7:0] b, input logic eop);
    int                  pos;
    swcrc_pkg::verdict_e vd;
    pos = hdr_pos;
    if (pos < swcrc_pkg::MAX_PACKET_BYTES) begin
      if (pos < swcrc_pkg::SEQ_START) begin
        crc_field = {crc_field[23:0], b};
      end else if (pos < swcrc_pkg::HEADER_BYTES) begin
        if (seq_digits_ok && b >= swcrc_pkg::ASCII_ZERO && b <= swcrc_pkg::ASCII_NINE) begin
          seq_parsed = swcrc_pkg::SEQ_W'(seq_parsed * 10 + (b - swcrc_pkg::ASCII_ZERO));
        end else begin
          seq_digits_ok = 1'b0;
        end
      end else begin
        crc_run = crc32_next(crc_run, b);
        // Pass the byte on only while it fits in what is left of the file.
        if (bytes_accepted < size_limit && pkt_emitted < size_limit - bytes_accepted) begin
          queue_word(swcrc_pkg::KIND_PAYLOAD, b, swcrc_pkg::VD_ACK_NEW, !eop);
          pkt_emitted++;
        end
      end
      hdr_pos = pos + 1;
    end
    if (eop) begin
      if (pos + 1 < swcrc_pkg::HEADER_BYTES || ~crc_run != crc_field) begin
        vd = swcrc_pkg::VD_RESEND;
      end else if (seq_wanted < seq_parsed) begin
        vd = swcrc_pkg::VD_SEQ_AHEAD;
      end else if (seq_wanted > seq_parsed) begin
        vd = swcrc_pkg::VD_ACK_DUP;
      end else begin
        vd = swcrc_pkg::VD_ACK_NEW;
        bytes_accepted += pkt_emitted;
        seq_wanted++;
        if (bytes_accepted >= size_limit) xfer_done = 1'b1;
      end
      queue_word(swcrc_pkg::KIND_VERDICT, 8'd0, vd, 1'b1);
      start_packet();
    end
  endtask

  always @(posedge clk_i) begin
    out_word_t got;
    out_word_t want;
    if (!rst_ni) begin
      size_limit     = '0;
      seq_wanted     = '0;
      bytes_accepted = '0;
      xfer_done      = 1'b0;
      words_seen     = 0;
      start_packet();
      words_due.delete();
    end else begin
      if (psel_i && penable_i && pready_i && paddr_i == FILE_SIZE_ADDR) begin
        if (pwrite_i) begin
          size_limit = pwdata_i;
        end else if (prdata_i !== size_limit) begin
          note_failure($sformatf("file size read: expected %08h, got %08h",
                                 size_limit, prdata_i));
        end
      end
      if (s_tvalid_i && s_tready_i) take_link_byte(s_tdata_i, s_tlast_i);
      if (m_tvalid_i && m_tready_i) begin
        got.kind      = m_tuser_i;
        got.data      = m_tdata_i[7:0];
        got.vd        = swcrc_pkg::verdict_e'(m_tdata_i[9:8]);
        got.seq       = m_tdata_i[23:10];
        got.committed = m_tdata_i[55:24];
        got.done      = m_tdata_i[56];
        got.pad       = m_tdata_i[63:57];
        got.last      = m_tlast_i;
        if (words_due.size() == 0) begin
          note_failure($sformatf("output word %0d not expected: %s", words_seen, show(got)));
        end else begin
          want = words_due.pop_front();
          if (got !== want) begin
            note_failure($sformatf("output word %0d mismatch\n  expected %s\n  got      %s",
                                   words_seen, show(want), show(got)));
          end
        end
        words_seen++;
      end
    end
    words_due_o = words_due.size();
  end

endmodule

### sim/tb_stop_wait_crc32_packet_receiver.sv
module tb_stop_wait_crc32_packet_receiver;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]  ADDR_FILE_SIZE = 3'd0;
  localparam logic [2:0]  ADDR_SPARE     = 3'd4;  // decodes to no register
  localparam logic [31:0] FS_MAX         = 32'hFFFF_FFFF;
  localparam int          PHASES         = 8;
  localparam int          PHASE_BYTES    = 70;
  localparam int          DRAIN_CYCLES   = 12;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
  typedef enum int {
    PKT_GOOD, PKT_DUP, PKT_AHEAD, PKT_BAD_CRC, PKT_SHORT, PKT_NON_DIGIT, PKT_NOISE
  } pkt_shape_e;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          words_due;

  int          send_idle_pct;
  int          recv_stall_pct;
  logic [7:0]  pkt_bytes[$];
  // Sequence the receiver waits for and bytes it has committed, tracked so that
  // most packets can be made to land.
  int          next_seq;
  logic [31:0] committed;
  logic [31:0] fsize;

  stop_wait_crc32_packet_receiver DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  packet_verdict_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tlast_i    (s_axis_tlast),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .m_tlast_i    (m_axis_tlast),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .words_due_o  (words_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("run did not finish in time, %0d output words still due", words_due);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct  = 51;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct = 51;
      end
      default: begin
        send_idle_pct  = 26;
        recv_stall_pct = 26;
      end
    endcase
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_file_size(input logic [31:0] value);
    apb_access(1'b1, ADDR_FILE_SIZE, value);
    apb_access(1'b0, ADDR_FILE_SIZE, 32'd0);
    fsize = value;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tlast  = last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_packet();
    foreach (pkt_bytes[i]) send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
  endtask

  // Let every owed word come out, then give the block time to settle.
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (words_due != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Only the first MAX_PACKET_BYTES bytes of a packet count toward the CRC.
  function automatic logic [31:0] payload_crc();
    logic [31:0] c;
    int          stop;
    c    = '1;
    stop = (pkt_bytes.size() < swcrc_pkg::MAX_PACKET_BYTES) ?
           pkt_bytes.size() : swcrc_pkg::MAX_PACKET_BYTES;
    for (int i = swcrc_pkg::HEADER_BYTES; i < stop; i++) begin
      c ^= {24'd0, pkt_bytes[i]};
      repeat (8) c = c[0] ? ((c >> 1) ^ swcrc_pkg::CRC_POLY) : (c >> 1);
    end
    return ~c;
  endfunction

  task automatic seal_crc();
    logic [31:0] crc;
    crc = payload_crc();
    pkt_bytes[0] = crc[31:24];
    pkt_bytes[1] = crc[23:16];
    pkt_bytes[2] = crc[15:8];
    pkt_bytes[3] = crc[7:0];
  endtask

  task automatic frame_packet(input int seq, input int len);
    int div;
    pkt_bytes.delete();
    repeat (swcrc_pkg::SEQ_START) pkt_bytes.push_back(8'd0);
    div = 1000;
    repeat (swcrc_pkg::HEADER_BYTES - swcrc_pkg::SEQ_START) begin
      pkt_bytes.push_back(8'(swcrc_pkg::ASCII_ZERO + (seq / div) % 10));
      div /= 10;
    end
    repeat (len) pkt_bytes.push_back(8'($urandom));
    seal_crc();
  endtask

  task automatic note_accepted();
    int pay;
    pay = ((pkt_bytes.size() < swcrc_pkg::MAX_PACKET_BYTES) ?
           pkt_bytes.size() : swcrc_pkg::MAX_PACKET_BYTES) - swcrc_pkg::HEADER_BYTES;
    if (committed < fsize) begin
      committed += (pay < fsize - committed) ? pay : fsize - committed;
    end
    next_seq++;
  endtask

  task automatic random_packet();
    pkt_shape_e shape;
    int         r;
    int         len;
    int         idx;
    int         parsed;
    logic [7:0] junk;
    r     = $urandom_range(99);
    shape = (r < 65) ? PKT_GOOD : (r < 72) ? PKT_DUP : (r < 78) ? PKT_AHEAD :
            (r < 86) ? PKT_BAD_CRC : (r < 91) ? PKT_SHORT : (r < 96) ? PKT_NON_DIGIT :
            PKT_NOISE;
    len   = ($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(40);
    case (shape)
      PKT_GOOD: begin
        frame_packet(next_seq, len);
        note_accepted();
      end
      PKT_DUP: begin
        frame_packet($urandom_range(next_seq - 1), len);
      end
      PKT_AHEAD: begin
        frame_packet(($urandom_range(3) == 0) ? 9999 : next_seq + 1 + $urandom_range(9), len);
      end
      PKT_BAD_CRC: begin
        frame_packet(next_seq, len);
        idx = (len > 0 && $urandom_range(1) == 1) ?
              swcrc_pkg::HEADER_BYTES + $urandom_range(len - 1) :
              $urandom_range(swcrc_pkg::SEQ_START - 1);
        pkt_bytes[idx] = pkt_bytes[idx] ^ 8'(1 << $urandom_range(7));
      end
      PKT_SHORT: begin
        pkt_bytes.delete();
        repeat ($urandom_range(swcrc_pkg::HEADER_BYTES - 1, 1)) begin
          pkt_bytes.push_back(8'($urandom));
        end
      end
      PKT_NON_DIGIT: begin
        frame_packet(next_seq, len);
        idx = $urandom_range(swcrc_pkg::HEADER_BYTES - 1, swcrc_pkg::SEQ_START);
        do junk = 8'($urandom);
        while (junk >= swcrc_pkg::ASCII_ZERO && junk <= swcrc_pkg::ASCII_NINE);
        pkt_bytes[idx] = junk;
        parsed = 0;
        for (int i = swcrc_pkg::SEQ_START; i < idx; i++) begin
          parsed = parsed * 10 + (pkt_bytes[i] - swcrc_pkg::ASCII_ZERO);
        end
        if (parsed == next_seq) note_accepted();
      end
      default: begin
        pkt_bytes.delete();
        repeat ($urandom_range(24, 1)) pkt_bytes.push_back(8'($urandom));
      end
    endcase
    send_packet();
  endtask

  initial begin
    int sent;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    s_axis_tlast  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = 3'd0;
    pwdata        = 32'd0;
    next_seq      = 0;
    committed     = 32'd0;
    fsize         = 32'd0;
    set_idling(IDLE_NONE);
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_file_size(FS_MAX);
    // A write that decodes to no register must leave the file size alone.
    apb_access(1'b1, ADDR_SPARE, $urandom);

    // Packet that ends inside the CRC field.
    pkt_bytes = '{8'hFF, 8'h00, 8'h80};
    send_packet();
    // Header only: the CRC of an empty payload is zero, so it is accepted.
    frame_packet(0, 0);
    send_packet();
    note_accepted();
    frame_packet(1, 0);
    pkt_bytes.push_back(8'h00);
    pkt_bytes.push_back(8'hFF);
    seal_crc();
    send_packet();
    note_accepted();
    // A non-digit right at the start of the sequence field parses as zero.
    frame_packet(next_seq, 0);
    pkt_bytes[swcrc_pkg::SEQ_START] = swcrc_pkg::ASCII_ZERO - 8'd1;
    send_packet();

    for (int ph = 1; ph <= PHASES; ph++) begin
      wait_drained();
      case (ph)
        1, 8: set_file_size(FS_MAX);
        2:    set_file_size(committed + 60);
        3:    set_file_size(32'd0);
        4:    set_file_size(committed + 150);
        5:    set_file_size($urandom);
        6:    set_file_size(committed + $urandom_range(100));
        default: set_file_size(committed);
      endcase
      apb_access(1'b1, ADDR_SPARE, $urandom);
      set_idling(idle_mode_e'((ph - 1) % 4));
      sent = 0;
      if (ph == 1) begin
        // Packet running past the maximum length; the tail is ignored.
        frame_packet(next_seq, swcrc_pkg::MAX_PACKET_BYTES - swcrc_pkg::HEADER_BYTES +
                               $urandom_range(12, 1));
        note_accepted();
        send_packet();
        sent += pkt_bytes.size();
      end
      while (sent < PHASE_BYTES) begin
        random_packet();
        sent += pkt_bytes.size();
      end
    end
    set_idling(IDLE_NONE);
    wait_drained();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
